FILE: rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, constants and the priority compare for the binary heap queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAPACITY  = 255;
  localparam int KEY_BITS  = 16;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS = CNT_BITS;           // slots 1..CAPACITY, slot 0 unused
  localparam int RAM_DEPTH = 1 << ADDR_BITS;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic MODE_MAX = 1'b0;              // larger key wins
  localparam logic MODE_MIN = 1'b1;              // smaller key wins

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    key_t    removed_key;
    cnt_t    occupancy;
  } res_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } ram_req_t;

  // a has equal or higher priority than b
  function automatic logic prio_ge(input logic mode, input key_t a, input key_t b);
    logic ge;
    if (mode == MODE_MIN) begin
      ge = (a <= b);
    end else begin
      ge = (a >= b);
    end
    return ge;
  endfunction

endpackage

FILE: rtl/bhpq_if.sv
// ----------------------------------------------------------------------------
// bhpq_if
// Valid/ready channels for the heap queue: request in, result out.
// ----------------------------------------------------------------------------
interface bhpq_in_if;
  logic            valid;
  logic            ready;
  logic            op;
  bhpq_pkg::key_t  key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface bhpq_out_if;
  logic              valid;
  logic              ready;
  bhpq_pkg::status_t status;
  bhpq_pkg::key_t    removed_key;
  bhpq_pkg::cnt_t    occupancy;

  modport source (output valid, output status, output removed_key, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input removed_key, input occupancy,
                  output ready);
endinterface

FILE: rtl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 16,
  parameter int ABITS = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr_a,
  input  logic [ABITS-1:0] raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [1 << ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/bhpq_ctrl.sv
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Heap sequencer: sift-up on insert, sift-down on delete, one level a cycle.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               order_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  bhpq_pkg::key_t     in_key,
  output logic               res_valid,
  input  logic               res_ready,
  output bhpq_pkg::res_t     res,
  output bhpq_pkg::ram_req_t ram_req,
  input  bhpq_pkg::key_t     rd_a,
  input  bhpq_pkg::key_t     rd_b
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_ROOT,
    S_DN_LOAD,
    S_DN,
    S_RES
  } state_t;

  typedef logic [bhpq_pkg::CNT_BITS:0] slot_w_t;

  state_t                 state_r,   state_nxt;
  bhpq_pkg::cnt_t         count_r,   count_nxt;
  bhpq_pkg::cnt_t         slot_r,    slot_nxt;
  bhpq_pkg::key_t         key_r,     key_nxt;     // insert key, or the moved last key
  bhpq_pkg::key_t         removed_r, removed_nxt;
  bhpq_pkg::res_t         res_r,     res_nxt;

  slot_w_t        left_w, right_w, cnt_w, gc_left_w;
  bhpq_pkg::cnt_t child, up_slot, ins_slot;
  bhpq_pkg::key_t child_key;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    slot_nxt    = slot_r;
    key_nxt     = key_r;
    removed_nxt = removed_r;
    res_nxt     = res_r;
    ram_req     = '0;

    left_w    = {slot_r, 1'b0};
    right_w   = left_w + slot_w_t'(1);
    cnt_w     = {1'b0, count_r};
    ins_slot  = count_r + bhpq_pkg::cnt_t'(1);
    up_slot   = slot_r >> 1;
    child     = slot_r;
    child_key = rd_a;
    gc_left_w = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == bhpq_pkg::OP_INSERT) begin
            if (cnt_w >= slot_w_t'(bhpq_pkg::CAPACITY)) begin
              res_nxt   = '{bhpq_pkg::ST_FULL, '0, count_r};
              state_nxt = S_RES;
            end else if (count_r == '0) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = bhpq_pkg::addr_t'(1);
              ram_req.wdata = in_key;
              count_nxt     = ins_slot;
              res_nxt       = '{bhpq_pkg::ST_OK, '0, ins_slot};
              state_nxt     = S_RES;
            end else begin
              ram_req.raddr_a = bhpq_pkg::addr_t'(ins_slot >> 1);
              count_nxt       = ins_slot;
              slot_nxt        = ins_slot;
              key_nxt         = in_key;
              state_nxt       = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt   = '{bhpq_pkg::ST_EMPTY, '0, count_r};
              state_nxt = S_RES;
            end else begin
              ram_req.raddr_a = bhpq_pkg::addr_t'(1);
              ram_req.raddr_b = bhpq_pkg::addr_t'(count_r);
              slot_nxt        = bhpq_pkg::cnt_t'(1);
              state_nxt       = S_DN_LOAD;
            end
          end
        end
      end

      S_UP: begin
        // rd_a holds the parent of slot_r
        ram_req.we = 1'b1;
        if (bhpq_pkg::prio_ge(order_mode, key_r, rd_a)) begin
          ram_req.waddr = bhpq_pkg::addr_t'(slot_r);
          ram_req.wdata = rd_a;
          slot_nxt      = up_slot;
          if (up_slot == bhpq_pkg::cnt_t'(1)) begin
            state_nxt = S_UP_ROOT;
          end else begin
            ram_req.raddr_a = bhpq_pkg::addr_t'(up_slot >> 1);
          end
        end else begin
          ram_req.waddr = bhpq_pkg::addr_t'(slot_r);
          ram_req.wdata = key_r;
          res_nxt       = '{bhpq_pkg::ST_OK, '0, count_r};
          state_nxt     = S_RES;
        end
      end

      S_UP_ROOT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = bhpq_pkg::addr_t'(1);
        ram_req.wdata = key_r;
        res_nxt       = '{bhpq_pkg::ST_OK, '0, count_r};
        state_nxt     = S_RES;
      end

      S_DN_LOAD: begin
        removed_nxt     = rd_a;
        key_nxt         = rd_b;
        ram_req.raddr_a = left_w[bhpq_pkg::ADDR_BITS-1:0];
        ram_req.raddr_b = right_w[bhpq_pkg::ADDR_BITS-1:0];
        state_nxt       = S_DN;
      end

      S_DN: begin
        // rd_a / rd_b hold the children of slot_r; count_r is still the old count
        ram_req.we = 1'b1;
        if (left_w > cnt_w) begin
          ram_req.waddr = bhpq_pkg::addr_t'(slot_r);
          ram_req.wdata = key_r;
          count_nxt     = count_r - bhpq_pkg::cnt_t'(1);
          res_nxt       = '{bhpq_pkg::ST_OK, removed_r, count_nxt};
          state_nxt     = S_RES;
        end else begin
          if (left_w == cnt_w || bhpq_pkg::prio_ge(order_mode, rd_a, rd_b)) begin
            child     = left_w[bhpq_pkg::CNT_BITS-1:0];
            child_key = rd_a;
          end else begin
            child     = right_w[bhpq_pkg::CNT_BITS-1:0];
            child_key = rd_b;
          end
          if (!bhpq_pkg::prio_ge(order_mode, key_r, child_key)) begin
            ram_req.waddr   = bhpq_pkg::addr_t'(slot_r);
            ram_req.wdata   = child_key;
            gc_left_w       = {child, 1'b0};
            ram_req.raddr_a = gc_left_w[bhpq_pkg::ADDR_BITS-1:0];
            ram_req.raddr_b = gc_left_w[bhpq_pkg::ADDR_BITS-1:0] + bhpq_pkg::addr_t'(1);
            slot_nxt        = child;
          end else begin
            ram_req.waddr = bhpq_pkg::addr_t'(slot_r);
            ram_req.wdata = key_r;
            count_nxt     = count_r - bhpq_pkg::cnt_t'(1);
            res_nxt       = '{bhpq_pkg::ST_OK, removed_r, count_nxt};
            state_nxt     = S_RES;
          end
        end
      end

      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    slot_r    <= slot_nxt;
    key_r     <= key_nxt;
    removed_r <= removed_nxt;
    res_r     <= res_nxt;
  end

endmodule

FILE: rtl/binary_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top
// Binary heap priority queue with insert/delete requests and one result each.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An insert compares the key with 0 to 7
// parents, with a final root write when the key rises to the root, and a
// delete visits 1 to 8 levels on the way down, for 255 keys. Each level
// needs one registered read from the heap RAM, which is overlapped with the
// write-back of the level above. A result sits in an output register, so the
// next request is taken while it waits. order_mode (cfg_wdata) selects
// max-heap (0) or min-heap (1); the user must see that it is written only
// while the queue is idle, as the block itself does not enforce this.
module binary_heap_priority_queue_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  bhpq_in_if.sink          in_chan,
  bhpq_out_if.source       out_chan
);

  logic               order_mode_r;
  logic               out_valid_r;
  bhpq_pkg::res_t     out_res_r;

  logic               res_valid;
  logic               res_ready;
  bhpq_pkg::res_t     res;
  bhpq_pkg::ram_req_t ram_req;
  bhpq_pkg::key_t     rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= bhpq_pkg::MODE_MAX;
    end else if (cfg_we) begin
      order_mode_r <= cfg_wdata;
    end
  end

  bhpq_ram #(
    .WIDTH (bhpq_pkg::KEY_BITS),
    .ABITS (bhpq_pkg::ADDR_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  bhpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .order_mode (order_mode_r),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_op      (in_chan.op),
    .in_key     (in_chan.key),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_req    (ram_req),
    .rd_a       (rd_a),
    .rd_b       (rd_b)
  );

  // output register: load when empty or draining this cycle
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.removed_key = out_res_r.removed_key;
  assign out_chan.occupancy   = out_res_r.occupancy;

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary heap priority queue. A heap model inside
// the bench predicts status, removed key and occupancy for every request. The
// results come back in order and are checked against that prediction. Stimulus
// covers directed corner cases, fill to full, drain to empty, mixed traffic in
// both orders, and a long output stall that backs up the request channel.
// ----------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  bhpq_in_if  in_chan();
  bhpq_out_if out_chan();

  binary_heap_priority_queue_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // heap model state
  bhpq_pkg::key_t heap_keys [1:bhpq_pkg::CAPACITY];
  int             heap_n;
  logic           heap_order;

  bhpq_pkg::res_t results_due [$];
  bhpq_pkg::res_t head_res;

  int err_cnt;
  int n_insert, n_delete, n_full, n_empty, n_checked;

  // sender pacing
  int tx_burst_left;
  bit tx_steady;
  // long output hold, consumed by the receiver process
  int rx_hold_req;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // true when a ranks equal to or above b under the current order
  function automatic bit ranks_ge(input bhpq_pkg::key_t a, input bhpq_pkg::key_t b);
    if (heap_order == bhpq_pkg::MODE_MIN) begin
      return a <= b;
    end
    return a >= b;
  endfunction

  function automatic bhpq_pkg::res_t heap_apply(input logic op, input bhpq_pkg::key_t key);
    bhpq_pkg::res_t r;
    int             slot;
    int             left;
    int             child;
    bhpq_pkg::key_t last;
    r.status      = bhpq_pkg::ST_OK;
    r.removed_key = '0;
    if (op == bhpq_pkg::OP_INSERT) begin
      if (heap_n >= bhpq_pkg::CAPACITY) begin
        r.status = bhpq_pkg::ST_FULL;
      end else begin
        heap_n++;
        slot = heap_n;
        // equal parent does not stop the climb
        while (slot > 1 && ranks_ge(key, heap_keys[slot / 2])) begin
          heap_keys[slot] = heap_keys[slot / 2];
          slot = slot / 2;
        end
        heap_keys[slot] = key;
      end
    end else begin
      if (heap_n == 0) begin
        r.status = bhpq_pkg::ST_EMPTY;
      end else begin
        last          = heap_keys[heap_n];
        r.removed_key = heap_keys[1];
        slot          = 1;
        forever begin
          left = slot * 2;
          if (left > heap_n) break;
          if (left == heap_n || ranks_ge(heap_keys[left], heap_keys[left + 1])) begin
            child = left;
          end else begin
            child = left + 1;
          end
          if (ranks_ge(last, heap_keys[child])) break;
          heap_keys[slot] = heap_keys[child];
          slot = child;
        end
        heap_keys[slot] = last;
        heap_n--;
      end
    end
    r.occupancy = bhpq_pkg::cnt_t'(heap_n);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: status %0d key %0h occ %0d",
               out_chan.status, out_chan.removed_key, out_chan.occupancy);
        err_cnt++;
      end else begin
        head_res = results_due.pop_front();
        n_checked++;
        if (out_chan.status !== head_res.status) begin
          $error("status: expected %0d, got %0d", head_res.status, out_chan.status);
          err_cnt++;
        end
        if (out_chan.removed_key !== head_res.removed_key) begin
          $error("removed_key: expected %0h, got %0h",
                 head_res.removed_key, out_chan.removed_key);
          err_cnt++;
        end
        if (out_chan.occupancy !== head_res.occupancy) begin
          $error("occupancy: expected %0d, got %0d",
                 head_res.occupancy, out_chan.occupancy);
          err_cnt++;
        end
      end
    end
  end

  // receiver: stall rate changes per segment, plus the occasional long hold
  initial begin : rx_drive
    int seg_left;
    int stall_pct;
    int hold_left;
    out_chan.ready = 1'b0;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2:    stall_pct = 25;
          3:    stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic op, input bhpq_pkg::key_t key);
    int gap;
    @(negedge clk);
    if (!tx_steady && tx_burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      tx_burst_left = $urandom_range(1, 20);
    end
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.key   <= key;
    do @(posedge clk); while (!in_chan.ready);
    // transfer taken at this edge
    results_due.push_back(heap_apply(op, key));
    if (op == bhpq_pkg::OP_INSERT) begin
      n_insert++;
      if (results_due[$].status == bhpq_pkg::ST_FULL) n_full++;
    end else begin
      n_delete++;
      if (results_due[$].status == bhpq_pkg::ST_EMPTY) n_empty++;
    end
    tx_burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_order(input logic mode);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    heap_order = mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bhpq_pkg::key_t pick_key();
    case ($urandom_range(0, 9))
      6, 7:    return bhpq_pkg::key_t'($urandom_range(0, 7));          // dense ties
      8:       return bhpq_pkg::key_t'($urandom_range(0, 1));
      9:       return bhpq_pkg::key_t'(16'hFFF8 + $urandom_range(0, 7));
      default: return bhpq_pkg::key_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic run_mix(input int n, input int insert_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        send_item(bhpq_pkg::OP_INSERT, pick_key());
      end else begin
        send_item(bhpq_pkg::OP_DELETE, bhpq_pkg::key_t'($urandom_range(0, 16'hFFFF)));
      end
    end
  endtask

  task automatic test_directed_max();
    send_item(bhpq_pkg::OP_DELETE, 16'h1234);              // empty
    send_item(bhpq_pkg::OP_INSERT, 16'h0000);
    send_item(bhpq_pkg::OP_INSERT, 16'hFFFF);
    send_item(bhpq_pkg::OP_INSERT, 16'h8000);
    send_item(bhpq_pkg::OP_INSERT, 16'h8000);
    send_item(bhpq_pkg::OP_INSERT, 16'h0001);
    send_item(bhpq_pkg::OP_INSERT, 16'hFFFF);              // equal to root
    repeat (7) send_item(bhpq_pkg::OP_DELETE, 16'hFFFF);   // last one hits empty
  endtask

  task automatic test_directed_min();
    set_order(bhpq_pkg::MODE_MIN);
    send_item(bhpq_pkg::OP_INSERT, 16'h0005);
    send_item(bhpq_pkg::OP_INSERT, 16'h0005);
    send_item(bhpq_pkg::OP_INSERT, 16'h0000);
    send_item(bhpq_pkg::OP_INSERT, 16'hFFFF);
    send_item(bhpq_pkg::OP_INSERT, 16'h0003);
    repeat (6) send_item(bhpq_pkg::OP_DELETE, 16'h0000);
  endtask

  // fill past capacity in max order, flip to min while full, then drain
  task automatic test_fill_drain();
    set_order(bhpq_pkg::MODE_MAX);
    run_mix(280, 97);
    set_order(bhpq_pkg::MODE_MIN);
    run_mix(280, 3);
  endtask

  task automatic test_mixed_orders();
    run_mix(350, 60);
    set_order(bhpq_pkg::MODE_MAX);
    run_mix(150, 50);
  endtask

  task automatic test_backpressure();
    wait_idle();
    tx_steady   = 1'b1;
    rx_hold_req = 400;
    run_mix(40, 50);
    tx_steady   = 1'b0;
    set_order(bhpq_pkg::MODE_MIN);
    run_mix(150, 30);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = bhpq_pkg::MODE_MAX;
    in_chan.valid = 1'b0;
    in_chan.op    = bhpq_pkg::OP_INSERT;
    in_chan.key   = '0;
    heap_n        = 0;
    heap_order    = bhpq_pkg::MODE_MAX;
    err_cnt       = 0;
    n_insert      = 0;
    n_delete      = 0;
    n_full        = 0;
    n_empty       = 0;
    n_checked     = 0;
    tx_burst_left = 0;
    tx_steady     = 1'b0;
    rx_hold_req   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_max();
    test_directed_min();
    test_fill_drain();
    test_mixed_orders();
    test_backpressure();
    wait_idle();

    $display("Ran %0d inserts (%0d refused full) and %0d deletes (%0d refused empty),",
             n_insert, n_full, n_delete, n_empty);
    $display("both orders, with output hold; %0d results checked, %0d errors.",
             n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
